// ----- rtl/core/bpc_pkg.sv -----
// shared types and constants for the barometer compensation block
// no dependencies; used by every module in rtl/core
package bpc_pkg;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int QUEUE_DEPTH = 4;

  localparam int TEMP_REF  = 2000;
  localparam int TEMP_LOW  = -1500;

  localparam int SHIFT_TEMP = 23;
  localparam int SHIFT_OFF  = 7;
  localparam int SHIFT_SENS = 8;
  localparam int SHIFT_T2   = 31;

  localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_SENSITIVITY   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_OFFSET        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY_TEMP_COEFF = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TEMP_COEFF      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_TEMPERATURE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEMPERATURE_COEFF      = 3'd5;

  typedef struct packed {
    logic [15:0] pressure_sensitivity;
    logic [15:0] pressure_offset;
    logic [15:0] sensitivity_temp_coeff;
    logic [15:0] offset_temp_coeff;
    logic [15:0] reference_temperature;
    logic [15:0] temperature_coeff;
  } cal_t;

  typedef struct packed {
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;
  } sample_t;

  typedef struct packed {
    logic signed [19:0] temperature_centi;
    logic signed [31:0] pressure_pascal;
  } result_t;

  // one classified sample between front and back
  typedef struct packed {
    logic [23:0]        d1;
    logic signed [18:0] dtemp;
    logic [17:0]        t2;
    logic [39:0]        off1;
    logic [39:0]        sens1;
    logic               low;
    logic               very_low;
  } qent_t;

endpackage

// ----- rtl/core/bpc_queue.sv -----
// small flop-based fifo between the front and back halves
// depends on bpc_pkg for the entry type
module bpc_queue #(
  parameter int DEPTH = bpc_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bpc_pkg::qent_t push_entry,
  output logic          full,
  input  logic          pop,
  output bpc_pkg::qent_t pop_entry,
  output logic          empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  bpc_pkg::qent_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign pop_entry = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + CNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + CNT_W'(1))
    else $error("queue count missed a push");

endmodule

// ----- rtl/core/bpc_front.sv -----
// front half: takes sample beats, forms dt and the first-order terms,
// classifies the temperature band and pushes into the queue; uses bpc_pkg
module bpc_front (
  input  logic             clk,
  input  logic             rst,
  input  bpc_pkg::cal_t    cal,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  bpc_pkg::sample_t sample,
  output logic             push,
  output bpc_pkg::qent_t   entry,
  input  logic             full
);

  localparam logic signed [18:0] VLOW_DT = 19'(bpc_pkg::TEMP_LOW - bpc_pkg::TEMP_REF);

  logic                en;
  logic                f1_valid;
  logic [23:0]         f1_d1;
  logic signed [24:0]  f1_dt;
  logic                f2_valid;
  logic [23:0]         f2_d1;
  logic signed [41:0]  f2_pt;
  logic signed [41:0]  f2_po;
  logic signed [41:0]  f2_ps;
  logic signed [49:0]  f2_pdd;
  logic signed [24:0]  dt;
  logic signed [18:0]  dtemp;

  assign en           = !(f2_valid && full);
  assign sample_stall = !en;
  assign push         = f2_valid && !full;

  assign dt = $signed({1'b0, sample.raw_temperature})
            - $signed({1'b0, cal.reference_temperature, 8'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= sample_valid;
      f2_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_d1  <= sample.raw_pressure;
      f1_dt  <= dt;
      f2_d1  <= f1_d1;
      f2_pt  <= f1_dt * $signed({1'b0, cal.temperature_coeff});
      f2_po  <= f1_dt * $signed({1'b0, cal.offset_temp_coeff});
      f2_ps  <= f1_dt * $signed({1'b0, cal.sensitivity_temp_coeff});
      f2_pdd <= f1_dt * f1_dt;
    end
  end

  // temperature relative to 20.00 c, before the second-order term
  assign dtemp = f2_pt[41:bpc_pkg::SHIFT_TEMP];

  always_comb begin
    entry.d1       = f2_d1;
    entry.dtemp    = dtemp;
    entry.t2       = f2_pdd[48:bpc_pkg::SHIFT_T2];
    entry.off1     = {8'b0, cal.pressure_offset, 16'b0}
                   + {{5{f2_po[41]}}, f2_po[41:bpc_pkg::SHIFT_OFF]};
    entry.sens1    = {9'b0, cal.pressure_sensitivity, 15'b0}
                   + {{6{f2_ps[41]}}, f2_ps[41:bpc_pkg::SHIFT_SENS]};
    entry.low      = dtemp[18];
    entry.very_low = (dtemp < VLOW_DT);
  end

endmodule

// ----- rtl/core/bpc_back.sv -----
// back half: pops classified samples, applies the second-order correction
// and the pressure product, holds the result beat; uses bpc_pkg
module bpc_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             empty,
  input  bpc_pkg::qent_t   entry,
  output logic             pop,
  output logic             result_valid,
  input  logic             result_stall,
  output bpc_pkg::result_t result
);

  localparam logic signed [18:0] LOW_GAP = 19'(bpc_pkg::TEMP_REF - bpc_pkg::TEMP_LOW);

  logic en;
  logic v0, v1, v2, v3, v4, v5;

  bpc_pkg::qent_t     b0;
  logic signed [18:0] b0_b;

  logic [23:0]        b1_d1;
  logic [39:0]        b1_off1, b1_sens1;
  logic [37:0]        b1_sq, b1_sq2;
  logic               b1_low, b1_vlow;
  logic signed [19:0] b1_temp;

  logic [39:0]        sq_w, sq2_w, sq5;
  logic [23:0]        b2_d1;
  logic [39:0]        b2_off1, b2_sens1, b2_offa, b2_sensa, b2_offb, b2_sensb;
  logic signed [19:0] b2_temp;

  logic [23:0]        b3_d1;
  logic [39:0]        b3_off, b3_sens;
  logic signed [19:0] b3_temp;

  logic [43:0]        b4_plo;
  logic signed [44:0] b4_phi;
  logic [39:0]        b4_off;
  logic signed [19:0] b4_temp;

  logic [63:0]        b5_prod;
  logic [39:0]        b5_off;
  logic signed [19:0] b5_temp;

  logic [43:0]        diff;

  assign en  = !result_valid || !result_stall;
  assign pop = en && !empty;

  assign b0_b  = b0.dtemp + LOW_GAP;
  assign sq_w  = {2'b0, b1_sq};
  assign sq2_w = {2'b0, b1_sq2};
  assign sq5   = (sq_w << 2) + sq_w;
  assign diff  = {b5_prod[63], b5_prod[63:21]} - {{4{b5_off[39]}}, b5_off};

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      v0 <= !empty;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      result_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b0 <= entry;

      // squares of the distance below 20.00 c and below -15.00 c
      b1_d1    <= b0.d1;
      b1_off1  <= b0.off1;
      b1_sens1 <= b0.sens1;
      b1_sq    <= 38'(b0.dtemp * b0.dtemp);
      b1_sq2   <= 38'(b0_b * b0_b);
      b1_low   <= b0.low;
      b1_vlow  <= b0.low && b0.very_low;
      b1_temp  <= 20'(b0.dtemp) + 20'(bpc_pkg::TEMP_REF)
                - (b0.low ? $signed({2'b0, b0.t2}) : 20'sd0);

      b2_d1    <= b1_d1;
      b2_off1  <= b1_off1;
      b2_sens1 <= b1_sens1;
      b2_temp  <= b1_temp;
      b2_offa  <= b1_low ? (sq5 >> 1) : '0;
      b2_sensa <= b1_low ? (sq5 >> 2) : '0;
      b2_offb  <= b1_vlow ? (sq2_w << 3) - sq2_w : '0;
      b2_sensb <= b1_vlow ? ((sq2_w << 3) + (sq2_w << 1) + sq2_w) >> 1 : '0;

      b3_d1    <= b2_d1;
      b3_temp  <= b2_temp;
      b3_off   <= b2_off1 - b2_offa - b2_offb;
      b3_sens  <= b2_sens1 - b2_sensa - b2_sensb;

      // split the 24 x 40 product into two narrow partial products
      b4_plo   <= {20'b0, b3_d1} * {24'b0, b3_sens[19:0]};
      b4_phi   <= $signed({1'b0, b3_d1}) * $signed(b3_sens[39:20]);
      b4_off   <= b3_off;
      b4_temp  <= b3_temp;

      b5_prod  <= {b4_phi[43:0], 20'b0} + {20'b0, b4_plo};
      b5_off   <= b4_off;
      b5_temp  <= b4_temp;

      result.temperature_centi <= b5_temp;
      result.pressure_pascal   <= $signed({{3{diff[43]}}, diff[43:15]});
    end
  end

endmodule

// ----- rtl/core/baro_pressure_temperature_compensation_top.sv -----
// top level: calibration registers, front half, queue and back half
// depends on bpc_pkg, bpc_front, bpc_queue, bpc_back
// throughput: one sample beat per cycle while sample_stall is low, set by the pipelined multiplier chain
// the queue lets the front keep taking beats while result beats are stalled
// reset clears the six calibration words to zero and empties every stage
module baro_pressure_temperature_compensation_top #(
  parameter int QUEUE_DEPTH = bpc_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             sample_valid,
  output logic                             sample_stall,
  input  bpc_pkg::sample_t                 sample,
  output logic                             result_valid,
  input  logic                             result_stall,
  output bpc_pkg::result_t                 result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  bpc_pkg::cal_t  cal;
  bpc_pkg::qent_t push_entry;
  bpc_pkg::qent_t pop_entry;
  logic           push;
  logic           pop;
  logic           full;
  logic           empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bpc_pkg::REG_PRESSURE_SENSITIVITY: begin
          cal.pressure_sensitivity <= cfg_data;
        end
        bpc_pkg::REG_PRESSURE_OFFSET: begin
          cal.pressure_offset <= cfg_data;
        end
        bpc_pkg::REG_SENSITIVITY_TEMP_COEFF: begin
          cal.sensitivity_temp_coeff <= cfg_data;
        end
        bpc_pkg::REG_OFFSET_TEMP_COEFF: begin
          cal.offset_temp_coeff <= cfg_data;
        end
        bpc_pkg::REG_REFERENCE_TEMPERATURE: begin
          cal.reference_temperature <= cfg_data;
        end
        bpc_pkg::REG_TEMPERATURE_COEFF: begin
          cal.temperature_coeff <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  bpc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cal          (cal),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .push         (push),
    .entry        (push_entry),
    .full         (full)
  );

  bpc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .empty      (empty)
  );

  bpc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (empty),
    .entry        (pop_entry),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for the barometer compensation block
// depends on bpc_pkg and baro_pressure_temperature_compensation_top
module tb_top;

  localparam int IDLE_LIMIT  = 4000;
  localparam int HOLD_CYCLES = 150;
  localparam int SETTLE      = 16;

  localparam logic [bpc_pkg::CFG_IDX_W-1:0] REG_SPARE_A =
    bpc_pkg::REG_TEMPERATURE_COEFF + 3'd1;
  localparam logic [bpc_pkg::CFG_IDX_W-1:0] REG_SPARE_B = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_stall;
  bpc_pkg::sample_t sample = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  bpc_pkg::result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bpc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  bpc_pkg::cal_t cal_words = '0;
  bpc_pkg::sample_t sample_backlog[$];
  bpc_pkg::result_t expected_readings[$];
  int errors = 0;
  int idle_cycles = 0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit sample_taken = 1'b0;
  bit steady_flow = 1'b0;
  bit hold_request = 1'b0;

  baro_pressure_temperature_compensation_top DUT (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample(sample),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic bpc_pkg::result_t compensate_reading(bpc_pkg::sample_t s);
    longint d1, d2, c1, c2, c3, c4, c5, c6;
    longint dt, off, sens, temp, t2, off2, sens2, below, sq, p;
    bpc_pkg::result_t r;
    d1 = s.raw_pressure;
    d2 = s.raw_temperature;
    c1 = cal_words.pressure_sensitivity;
    c2 = cal_words.pressure_offset;
    c3 = cal_words.sensitivity_temp_coeff;
    c4 = cal_words.offset_temp_coeff;
    c5 = cal_words.reference_temperature;
    c6 = cal_words.temperature_coeff;
    dt = d2 - c5 * 256;
    off = c2 * 65536 + ((c4 * dt) >>> 7);
    sens = c1 * 32768 + ((c3 * dt) >>> 8);
    temp = bpc_pkg::TEMP_REF + ((dt * c6) >>> 23);
    t2 = 0;
    off2 = 0;
    sens2 = 0;
    if (temp < bpc_pkg::TEMP_REF) begin
      sq = (temp - bpc_pkg::TEMP_REF) * (temp - bpc_pkg::TEMP_REF);
      t2 = (dt * dt) >>> 31;
      off2 = (5 * sq) >>> 1;
      sens2 = (5 * sq) >>> 2;
      if (temp < bpc_pkg::TEMP_LOW) begin
        below = (temp - bpc_pkg::TEMP_LOW) * (temp - bpc_pkg::TEMP_LOW);
        off2 += 7 * below;
        sens2 += (11 * below) >>> 1;
      end
    end
    temp -= t2;
    off -= off2;
    sens -= sens2;
    p = (((d1 * sens) >>> 21) - off) >>> 15;
    r.temperature_centi = temp[19:0];
    r.pressure_pascal = p[31:0];
    return r;
  endfunction

  // half with no gap, most of the rest short, a few long
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [23:0] clamp24(longint v);
    if (v < 0) return '0;
    if (v > 24'hFFFFFF) return '1;
    return v[23:0];
  endfunction

  function automatic logic [15:0] random_word();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return '1;
    return 16'($urandom);
  endfunction

  function automatic bpc_pkg::sample_t random_sample();
    bpc_pkg::sample_t s;
    int unsigned r;
    longint span;
    r = $urandom_range(0, 99);
    if (r < 80) s.raw_pressure = 24'($urandom);
    else if (r < 90) s.raw_pressure = '0;
    else s.raw_pressure = '1;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      s.raw_temperature = 24'($urandom);
    end else if (r < 85) begin
      // cluster around the reference reading to hit both cold corrections
      span = longint'($urandom_range(0, 1 << $urandom_range(0, 22)));
      if ($urandom_range(0, 1)) span = -span;
      s.raw_temperature = clamp24(longint'(cal_words.reference_temperature) * 256 + span);
    end else if (r < 92) begin
      s.raw_temperature = '0;
    end else begin
      s.raw_temperature = '1;
    end
    return s;
  endfunction

  task automatic queue_sample(longint d1, longint d2);
    bpc_pkg::sample_t s;
    s.raw_pressure = clamp24(d1);
    s.raw_temperature = clamp24(d2);
    sample_backlog.push_back(s);
  endtask

  task automatic queue_random(int count);
    repeat (count) sample_backlog.push_back(random_sample());
  endtask

  task automatic wait_idle();
    while (sample_backlog.size() != 0 || sample_valid || expected_readings.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cal_word(logic [bpc_pkg::CFG_IDX_W-1:0] idx,
                                logic [bpc_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      bpc_pkg::REG_PRESSURE_SENSITIVITY:   cal_words.pressure_sensitivity = data;
      bpc_pkg::REG_PRESSURE_OFFSET:        cal_words.pressure_offset = data;
      bpc_pkg::REG_SENSITIVITY_TEMP_COEFF: cal_words.sensitivity_temp_coeff = data;
      bpc_pkg::REG_OFFSET_TEMP_COEFF:      cal_words.offset_temp_coeff = data;
      bpc_pkg::REG_REFERENCE_TEMPERATURE:  cal_words.reference_temperature = data;
      bpc_pkg::REG_TEMPERATURE_COEFF:      cal_words.temperature_coeff = data;
      default: ;
    endcase
  endtask

  task automatic load_calibration(bpc_pkg::cal_t words, bit with_spare);
    if (with_spare) begin
      write_cal_word(REG_SPARE_A, 16'($urandom));
      write_cal_word(REG_SPARE_B, 16'($urandom));
    end
    write_cal_word(bpc_pkg::REG_PRESSURE_SENSITIVITY, words.pressure_sensitivity);
    write_cal_word(bpc_pkg::REG_PRESSURE_OFFSET, words.pressure_offset);
    write_cal_word(bpc_pkg::REG_SENSITIVITY_TEMP_COEFF, words.sensitivity_temp_coeff);
    write_cal_word(bpc_pkg::REG_OFFSET_TEMP_COEFF, words.offset_temp_coeff);
    write_cal_word(bpc_pkg::REG_REFERENCE_TEMPERATURE, words.reference_temperature);
    write_cal_word(bpc_pkg::REG_TEMPERATURE_COEFF, words.temperature_coeff);
    if (with_spare) write_cal_word(REG_SPARE_A, 16'($urandom));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // sample driver
  always @(negedge clk) begin
    if (!sample_valid || sample_taken) begin
      sample_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        sample_valid <= 1'b0;
      end else if (sample_backlog.size() != 0) begin
        sample <= sample_backlog.pop_front();
        sample_valid <= 1'b1;
        gap_left = steady_flow ? 0 : pick_gap();
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      if (stall_left == 0 && !steady_flow) stall_left = pick_gap();
      if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // monitor, scoreboard and watchdog
  always @(posedge clk) begin
    bpc_pkg::result_t want;
    bit moved;
    moved = 1'b0;
    if (!rst) begin
      if (sample_valid && !sample_stall) begin
        expected_readings.push_back(compensate_reading(sample));
        sample_taken = 1'b1;
        moved = 1'b1;
      end
      if (result_valid && !result_stall) begin
        moved = 1'b1;
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected result beat, temperature_centi %0d pressure_pascal %0d",
                   $time, result.temperature_centi, result.pressure_pascal);
          errors++;
        end else begin
          want = expected_readings.pop_front();
          if (result.temperature_centi !== want.temperature_centi) begin
            $display("%0t: temperature_centi expected %0d actual %0d",
                     $time, want.temperature_centi, result.temperature_centi);
            errors++;
          end
          if (result.pressure_pascal !== want.pressure_pascal) begin
            $display("%0t: pressure_pascal expected %0d actual %0d",
                     $time, want.pressure_pascal, result.pressure_pascal);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) moved = 1'b1;
    end
    if (moved) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
      $display("baro_pressure_temperature_compensation_top test failed");
      $finish;
    end
  end

  initial begin
    bpc_pkg::cal_t words;
    longint ref_reading;
    longint cold_edge;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // reset calibration, all zero
    queue_random(40);
    wait_idle();

    // typical factory words, directed corners first
    words.pressure_sensitivity = 16'd40127;
    words.pressure_offset = 16'd36924;
    words.sensitivity_temp_coeff = 16'd23317;
    words.offset_temp_coeff = 16'd23282;
    words.reference_temperature = 16'd33464;
    words.temperature_coeff = 16'd28312;
    load_calibration(words, 1'b0);
    ref_reading = longint'(cal_words.reference_temperature) * 256;
    cold_edge = -((longint'(bpc_pkg::TEMP_REF - bpc_pkg::TEMP_LOW) <<< 23)
                  / cal_words.temperature_coeff);
    queue_sample(9085466, ref_reading);
    queue_sample(9085466, ref_reading - 1);
    queue_sample(9085466, ref_reading + 1);
    queue_sample(9085466, ref_reading + cold_edge);
    queue_sample(9085466, ref_reading + cold_edge - 1);
    queue_sample(9085466, 0);
    queue_sample(9085466, 24'hFFFFFF);
    queue_sample(0, ref_reading);
    queue_sample(24'hFFFFFF, ref_reading);
    queue_sample(24'h800000, ref_reading);
    queue_sample(24'h7FFFFF, ref_reading);
    queue_sample(0, 0);
    queue_sample(24'hFFFFFF, 0);
    queue_sample(0, 24'hFFFFFF);
    queue_sample(24'hFFFFFF, 24'hFFFFFF);
    queue_sample(24'hAAAAAA, 24'h555555);
    queue_sample(24'h555555, 24'hAAAAAA);
    queue_random(260);
    hold_request = 1'b1;
    wait_idle();

    // every word at full scale, pressure wraps
    load_calibration('1, 1'b0);
    queue_sample(0, 0);
    queue_sample(24'hFFFFFF, 0);
    queue_sample(0, 24'hFFFFFF);
    queue_sample(24'hFFFFFF, 24'hFFFFFF);
    steady_flow = 1'b1;
    queue_random(150);
    wait_idle();
    steady_flow = 1'b0;

    // zeros written back, writes past the register list ignored
    load_calibration('0, 1'b1);
    queue_random(80);
    wait_idle();

    for (int phase = 0; phase < 6; phase++) begin
      words.pressure_sensitivity = random_word();
      words.pressure_offset = random_word();
      words.sensitivity_temp_coeff = random_word();
      words.offset_temp_coeff = random_word();
      words.reference_temperature = random_word();
      words.temperature_coeff = random_word();
      load_calibration(words, phase[0]);
      steady_flow = (phase == 3);
      queue_random(150);
      wait_idle();
      steady_flow = 1'b0;
    end

    if (errors == 0 && expected_readings.size() == 0) begin
      $display("baro_pressure_temperature_compensation_top test passed");
    end else begin
      $display("baro_pressure_temperature_compensation_top test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/bpc_pkg.sv
rtl/core/bpc_queue.sv
rtl/core/bpc_front.sv
rtl/core/bpc_back.sv
rtl/core/baro_pressure_temperature_compensation_top.sv
tb/tb_top.sv
